// File: hw/rtl/dsct_pkg.sv
// Package for the DMA source-chain tag step: tag kinds, status codes,
// field widths and the quadword size. No dependencies.
`default_nettype none

package dsct_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned QWC_W = 16;
    localparam int unsigned DEPTH_W = 2;
    // 16-byte quadword: byte offset is the count shifted by four
    localparam int unsigned QW_SHIFT = 4;
    localparam logic [ADDR_W-1:0] QW_BYTES = 32'd16;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [QWC_W-1:0] qwc_t;
    typedef logic [DEPTH_W-1:0] depth_t;

    typedef enum logic [2:0] {
        KIND_REFE = 3'd0,
        KIND_CNT  = 3'd1,
        KIND_NEXT = 3'd2,
        KIND_REF  = 3'd3,
        KIND_REFS = 3'd4,
        KIND_CALL = 3'd5,
        KIND_RET  = 3'd6,
        KIND_END  = 3'd7
    } tag_kind_t;

    typedef enum logic [1:0] {
        ST_CONTINUE    = 2'd0,
        ST_END         = 2'd1,
        ST_OVERFLOW    = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } status_t;

    // mode field values
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TAG   = 1'b1;

    // stack fill levels
    localparam depth_t DEPTH_EMPTY = 2'd0;
    localparam depth_t DEPTH_ONE   = 2'd1;
    localparam depth_t DEPTH_FULL  = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/dsct_in_if.sv
// Tag input channel: valid/ready plus one tag word.
// Depends on dsct_pkg.
`default_nettype none

interface dsct_in_if;
    import dsct_pkg::*;

    logic      valid;
    logic      ready;
    logic      mode;
    tag_kind_t tag_kind;
    addr_t     address;
    qwc_t      quadword_count;

    modport source (output valid, output mode, output tag_kind, output address,
                    output quadword_count, input ready);
    modport sink (input valid, input mode, input tag_kind, input address,
                  input quadword_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dsct_out_if.sv
// Step result channel: valid/ready plus one result word.
// Depends on dsct_pkg.
`default_nettype none

interface dsct_out_if;
    import dsct_pkg::*;

    logic    valid;
    logic    ready;
    addr_t   data_address;
    addr_t   next_tag_address;
    status_t status;
    depth_t  stack_depth;

    modport source (output valid, output data_address, output next_tag_address,
                    output status, output stack_depth, input ready);
    modport sink (input valid, input data_address, input next_tag_address,
                  input status, input stack_depth, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dsct_cfg_if.sv
// Configuration write channel: valid/ready plus the call-stack enable bit.
// No dependencies.
`default_nettype none

interface dsct_cfg_if;
    logic valid;
    logic ready;
    logic call_stack_enabled;

    modport source (output valid, output call_stack_enabled, input ready);
    modport sink (input valid, input call_stack_enabled, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dma_source_chain_tag_step_unit.sv
// Top level of the DMA source-chain tag step unit.
// Depends on dsct_pkg, dsct_in_if, dsct_out_if and dsct_cfg_if.
//
// Usage:
//   tags  - input words: a start word (mode 0) loads the tag pointer and
//           empties the two-entry return-address stack; a tag word (mode 1)
//           decodes one chain tag.
//   steps - one result word per input word: data address, next tag address,
//           status and stack depth after the step.
//   cfg   - write channel for the call-stack enable bit; always ready.
//           Write only while no word is in flight.
// Flow: a word accepted is held in the input register, then decoded against
// the tag pointer and stack into the result register, from which steps
// takes it.
// Throughput: one word per cycle while steps is taken, set by the single
// decode stage between the input and result registers, which also updates the state.
// Stall: when steps is not taken, the result register holds; the input
// register still accepts one more word, then tags.ready drops.
// Reset: tag pointer, stack and count go to zero, call stack enabled, both
// stages empty.
`default_nettype none

module dma_source_chain_tag_step_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dsct_in_if.sink     tags,
    dsct_out_if.source  steps,
    dsct_cfg_if.sink    cfg
);
    import dsct_pkg::*;

    // configuration
    logic cs_en_reg;

    // input stage
    logic      in_valid_reg;
    logic      mode_reg;
    tag_kind_t kind_reg;
    addr_t     addr_reg;
    qwc_t      qwc_reg;

    // chain state
    addr_t  tp_reg, tp_next;
    addr_t  ret_lo_reg, ret_lo_next;
    addr_t  ret_hi_reg, ret_hi_next;
    depth_t cnt_reg, cnt_next;

    // result stage
    logic    out_valid_reg;
    addr_t   data_reg, data_next;
    status_t status_reg, status_next;

    logic  advance;
    addr_t after;
    addr_t ret_addr;

    // stage handshakes
    assign advance    = !out_valid_reg || steps.ready;
    assign tags.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_en_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            cs_en_reg <= cfg.call_stack_enabled;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tags.ready)
        begin
            in_valid_reg <= tags.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tags.valid && tags.ready)
        begin
            mode_reg <= tags.mode;
            kind_reg <= tags.tag_kind;
            addr_reg <= tags.address;
            qwc_reg  <= tags.quadword_count;
        end
    end

    // address after the tag, and return address past the tag's data
    assign after    = tp_reg + QW_BYTES;
    assign ret_addr = after + (addr_t'(qwc_reg) << QW_SHIFT);

    // tag decode
    always_comb
    begin
        tp_next     = tp_reg;
        ret_lo_next = ret_lo_reg;
        ret_hi_next = ret_hi_reg;
        cnt_next    = cnt_reg;
        data_next   = after;
        status_next = ST_CONTINUE;

        if (mode_reg == MODE_START)
        begin
            tp_next     = addr_reg;
            ret_lo_next = '0;
            ret_hi_next = '0;
            cnt_next    = DEPTH_EMPTY;
            data_next   = '0;
        end
        else
        begin
            unique case (kind_reg)
                KIND_REFE:
                begin
                    data_next   = addr_reg;
                    tp_next     = after;
                    status_next = ST_END;
                end
                KIND_CNT:
                begin
                    tp_next = after;
                end
                KIND_NEXT:
                begin
                    tp_next = addr_reg;
                end
                KIND_REF, KIND_REFS:
                begin
                    data_next = addr_reg;
                    tp_next   = after;
                end
                KIND_CALL:
                begin
                    if (!cs_en_reg)
                    begin
                        data_next   = addr_reg;
                        status_next = ST_UNSUPPORTED;
                    end
                    else if (cnt_reg == DEPTH_EMPTY)
                    begin
                        ret_lo_next = ret_addr;
                        cnt_next    = DEPTH_ONE;
                        tp_next     = addr_reg;
                    end
                    else if (cnt_reg == DEPTH_ONE)
                    begin
                        ret_hi_next = ret_addr;
                        cnt_next    = DEPTH_FULL;
                        tp_next     = addr_reg;
                    end
                    else
                    begin
                        status_next = ST_OVERFLOW;
                    end
                end
                KIND_RET:
                begin
                    if (!cs_en_reg)
                    begin
                        data_next   = addr_reg;
                        status_next = ST_UNSUPPORTED;
                    end
                    else if (cnt_reg == DEPTH_FULL)
                    begin
                        tp_next     = ret_hi_reg;
                        ret_hi_next = '0;
                        cnt_next    = DEPTH_ONE;
                    end
                    else if (cnt_reg == DEPTH_ONE)
                    begin
                        tp_next     = ret_lo_reg;
                        ret_lo_next = '0;
                        cnt_next    = DEPTH_EMPTY;
                    end
                    else
                    begin
                        status_next = ST_END;
                    end
                end
                KIND_END:
                begin
                    status_next = ST_END;
                end
                default:
                begin
                    status_next = ST_END;
                end
            endcase
        end
    end

    // chain state, updated as a word leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg     <= '0;
            ret_lo_reg <= '0;
            ret_hi_reg <= '0;
            cnt_reg    <= DEPTH_EMPTY;
        end
        else if (in_valid_reg && advance)
        begin
            tp_reg     <= tp_next;
            ret_lo_reg <= ret_lo_next;
            ret_hi_reg <= ret_hi_next;
            cnt_reg    <= cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    assign steps.valid            = out_valid_reg;
    assign steps.data_address     = data_reg;
    assign steps.next_tag_address = tp_reg;
    assign steps.status           = status_reg;
    assign steps.stack_depth      = cnt_reg;

endmodule

`default_nettype wire
